// ----- rtl/core/mprmt_pkg.sv -----
// ============================================================================
// mprmt_pkg
// Shared types and constants for the MIDI part rhythm-mode tracker.
// ============================================================================
package mprmt_pkg;

    localparam int PART_COUNT = 16;
    localparam int PART_W     = 4;
    localparam int HDR_DEPTH  = 10;

    localparam logic [1:0] OP_SYSEX = 2'd0;
    localparam logic [1:0] OP_BANK  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] MODE_XG  = 2'd0;
    localparam logic [1:0] MODE_GM2 = 2'd1;
    localparam logic [1:0] MODE_GS  = 2'd2;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_XG_RHY   = 3'd1;
    localparam logic [2:0] REG_GM2_RHY  = 3'd2;
    localparam logic [2:0] REG_GM2_MEL  = 3'd3;
    localparam logic [2:0] REG_DEF_PART = 3'd4;

    // command handed from front to back
    typedef enum logic [3:0] {
        CMD_NONE  = 4'b0001,
        CMD_SET   = 4'b0010,
        CMD_QUERY = 4'b0100,
        CMD_CLEAR = 4'b1000
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] part;
        logic [3:0] other_part;
        logic [1:0] map;       // 0..2 direct map; with one_bit set, want selects rhythm or melodic
        logic       one_bit;   // map request is rhythm/melodic only
        logic       want;
        logic       mark;
        logic       bank_op;   // bank select: check explicit flag and mode
        logic [6:0] bank_msb;
        logic [6:0] bank_lsb;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    typedef struct packed {
        logic       change_valid;
        logic [3:0] change_part;
        logic       change_rhythm;
        logic       is_rhythm;
        logic [6:0] effective_msb;
        logic [6:0] effective_lsb;
        logic       shares_map;
    } t_result;

    function automatic logic [4:0] gs_part(input logic [7:0] blk);
        logic [4:0] r;
        r = 5'h1f;
        if (blk == 8'h10) r = 5'd9;
        else if (blk >= 8'h11 && blk <= 8'h19) r = 5'(blk - 8'h11);
        else if (blk >= 8'h1a && blk <= 8'h1f) r = 5'(blk - 8'h10);
        return r;
    endfunction

endpackage

// ----- rtl/core/mprmt_front.sv -----
// ============================================================================
// mprmt_front
// Accepts items, assembles system exclusive messages and issues commands.
// ============================================================================
module mprmt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  logic [3:0]           i_part,
    input  logic [3:0]           i_other_part,
    input  logic [6:0]           i_bank_msb,
    input  logic [6:0]           i_bank_lsb,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mprmt_pkg::t_item     o_item
);

    logic [7:0] r_hdr [mprmt_pkg::HDR_DEPTH];
    logic [3:0] r_cnt, n_cnt;
    logic       r_hit, n_hit, r_drum, n_drum;
    logic [7:0] h6;
    logic [4:0] idx1;
    logic [6:0] sum, ck;
    logic [4:0] gp;
    logic       gs_ok, xg_ok;
    mprmt_pkg::t_item item;

    assign o_valid = i_valid;
    assign o_ready = i_ready;
    assign h6 = (r_cnt == 4'd6) ? i_data_byte : r_hdr[6];
    assign idx1 = 5'(r_cnt) + 5'd1;
    assign sum = 7'(r_hdr[5] + r_hdr[6] + r_hdr[7] + r_hdr[8]);
    assign ck = 7'(8'h80 - {1'b0, sum});
    assign gp = mprmt_pkg::gs_part(r_hdr[6]);

    always_comb begin
        gs_ok = idx1 == 5'd11 && r_hdr[0] == 8'hf0 && r_hdr[1] == 8'h41
            && r_hdr[2] <= 8'h1f && r_hdr[3] == 8'h42 && r_hdr[4] == 8'h12
            && r_hdr[5] == 8'h40 && r_hdr[7] == 8'h15 && r_hdr[8] <= 8'h02
            && i_data_byte == 8'hf7 && gp < 5'(mprmt_pkg::PART_COUNT)
            && r_hdr[9] == {1'b0, ck};
        xg_ok = idx1 >= 5'd9 && r_hdr[0] == 8'hf0 && i_data_byte == 8'hf7
            && r_hdr[1] == 8'h43 && r_hdr[2][7:4] == 4'h1 && r_hdr[3] == 8'h4c
            && r_hdr[4] == 8'h08 && r_hdr[5] < 8'(mprmt_pkg::PART_COUNT) && r_hit;
    end

    always_comb begin
        item = '0;
        item.cmd = mprmt_pkg::CMD_NONE;
        item.part = i_part;
        item.other_part = i_other_part;
        item.bank_msb = i_bank_msb;
        item.bank_lsb = i_bank_lsb;
        n_cnt = r_cnt;
        n_hit = r_hit;
        n_drum = r_drum;
        unique case (i_op)
            mprmt_pkg::OP_SYSEX: begin
                if (i_last_byte) begin
                    n_cnt = '0;
                    n_hit = 1'b0;
                    n_drum = 1'b0;
                    item.mark = 1'b1;
                    if (gs_ok) begin
                        item.cmd = mprmt_pkg::CMD_SET;
                        item.part = gp[3:0];
                        item.map = r_hdr[8][1:0];
                    end else if (xg_ok) begin
                        item.cmd = mprmt_pkg::CMD_SET;
                        item.part = r_hdr[5][3:0];
                        item.one_bit = 1'b1;
                        item.want = r_drum;
                    end
                end else begin
                    if (r_cnt >= 4'd7 && 9'(h6) + 9'(r_cnt) == 9'd14) begin
                        n_hit = 1'b1;
                        n_drum = i_data_byte != 8'd0;
                    end
                    if (r_cnt != 4'd15) n_cnt = r_cnt + 4'd1;
                end
            end
            mprmt_pkg::OP_BANK: begin
                item.cmd = mprmt_pkg::CMD_SET;
                item.bank_op = 1'b1;
                item.one_bit = 1'b1;
            end
            mprmt_pkg::OP_QUERY: item.cmd = mprmt_pkg::CMD_QUERY;
            default:             item.cmd = mprmt_pkg::CMD_CLEAR;
        endcase
    end

    assign o_item = item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_hit <= 1'b0;
            r_drum <= 1'b0;
        end else if (i_valid && i_ready) begin
            r_cnt <= n_cnt;
            r_hit <= n_hit;
            r_drum <= n_drum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_ready && i_op == mprmt_pkg::OP_SYSEX
            && r_cnt < 4'(mprmt_pkg::HDR_DEPTH)) begin
            r_hdr[r_cnt] <= i_data_byte;
        end
    end

endmodule

// ----- rtl/core/mprmt_queue.sv -----
// ============================================================================
// mprmt_queue
// Two-entry command queue between front and back.
// ============================================================================
module mprmt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mprmt_pkg::t_item i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output mprmt_pkg::t_item o_item
);

    mprmt_pkg::t_item r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= 2'(r_cnt + 2'(push) - 2'(pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end

endmodule

// ----- rtl/core/mprmt_back.sv -----
// ============================================================================
// mprmt_back
// Holds per-part maps and explicit flags; executes commands into results.
// ============================================================================
module mprmt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mprmt_pkg::t_item i_item,
    input  logic [1:0]       i_mode,
    input  logic [6:0]       i_xg_rhy,
    input  logic [6:0]       i_gm2_rhy,
    input  logic [6:0]       i_gm2_mel,
    input  logic [3:0]       i_def_part,
    output logic             o_valid,
    input  logic             i_ready,
    output mprmt_pkg::t_result o_res
);

    logic [1:0] r_map [mprmt_pkg::PART_COUNT];
    logic [mprmt_pkg::PART_COUNT-1:0] r_expl;
    logic r_ovalid;
    mprmt_pkg::t_result r_res, res;
    logic fire, emit, do_write, p_ok, q_ok, rp, rq, want, skip;
    logic [1:0] cur, newmap, mp, mq;

    assign o_ready = !r_ovalid || i_ready;
    assign fire = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_res = r_res;

    assign p_ok = 5'(i_item.part) < 5'(mprmt_pkg::PART_COUNT);
    assign q_ok = 5'(i_item.other_part) < 5'(mprmt_pkg::PART_COUNT);
    assign mp = p_ok ? r_map[i_item.part] : 2'd0;
    assign mq = q_ok ? r_map[i_item.other_part] : 2'd0;
    assign rp = mp != 2'd0;
    assign rq = mq != 2'd0;
    assign cur = mp;

    always_comb begin
        res = '0;
        emit = 1'b0;
        do_write = 1'b0;
        skip = 1'b0;
        want = i_item.want;
        newmap = i_item.map;
        if (i_item.bank_op) begin
            skip = !p_ok || r_expl[i_item.part];
            priority if (i_mode == mprmt_pkg::MODE_XG) want = i_item.bank_msb == i_xg_rhy;
            else if (i_mode == mprmt_pkg::MODE_GM2) begin
                if (i_item.bank_msb == i_gm2_rhy) want = 1'b1;
                else if (i_item.bank_msb == i_gm2_mel) want = 1'b0;
                else skip = 1'b1;
            end else skip = 1'b1;
        end
        if (i_item.one_bit) newmap = {1'b0, want};
        unique case (i_item.cmd)
            mprmt_pkg::CMD_SET: begin
                if (!skip && (i_item.one_bit ? (rp != want) : (cur != newmap))) begin
                    emit = 1'b1;
                    do_write = 1'b1;
                    res.change_valid = 1'b1;
                    res.change_part = i_item.part;
                    res.change_rhythm = newmap != 2'd0;
                end
            end
            mprmt_pkg::CMD_QUERY: begin
                emit = 1'b1;
                res.is_rhythm = rp;
                res.effective_msb = rp ? ((i_mode == mprmt_pkg::MODE_XG) ? i_xg_rhy
                    : i_gm2_rhy) : i_item.bank_msb;
                res.effective_lsb = rp ? 7'd0 : i_item.bank_lsb;
                res.shares_map = i_mode == mprmt_pkg::MODE_GS && rp && rq && mp == mq;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_expl <= '0;
            for (int i = 0; i < mprmt_pkg::PART_COUNT; i++)
                r_map[i] <= (4'(i) == i_def_part) ? 2'd1 : 2'd0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (fire) begin
                if (emit) r_ovalid <= 1'b1;
                if (i_item.cmd == mprmt_pkg::CMD_CLEAR) begin
                    r_expl <= '0;
                    for (int i = 0; i < mprmt_pkg::PART_COUNT; i++)
                        r_map[i] <= (4'(i) == i_def_part) ? 2'd1 : 2'd0;
                end else if (i_item.cmd == mprmt_pkg::CMD_SET && p_ok) begin
                    if (i_item.mark) r_expl[i_item.part] <= 1'b1;
                    if (do_write) r_map[i_item.part] <= newmap;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) r_res <= res;
    end

endmodule

// ----- rtl/core/midi_part_rhythm_mode_tracker_top.sv -----
// ============================================================================
// midi_part_rhythm_mode_tracker_top
// Per-part rhythm map tracker driven by sysex bytes and bank selects.
// ============================================================================
// One item per clock sustained while the output is not stalled: the front
// decodes a sysex byte or event combinationally, a two-entry queue feeds
// the back, which updates the part table and registers at most one result.
// Configuration writes take effect at once.
module midi_part_rhythm_mode_tracker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] op, [9:2] data_byte, [13:10] part, [17:14] other_part,
    // [24:18] bank_msb, [31:25] bank_lsb
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] change_valid, [4:1] change_part, [5] change_rhythm, [6] is_rhythm,
    // [13:7] effective_msb, [20:14] effective_lsb, [21] shares_map
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata
);

    logic [1:0] r_mode;
    logic [6:0] r_xg_rhy, r_gm2_rhy, r_gm2_mel;
    logic [3:0] r_def_part;
    logic f_valid, f_ready, q_valid, q_ready;
    mprmt_pkg::t_item f_item, q_item;
    mprmt_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
            r_xg_rhy <= 7'd127;
            r_gm2_rhy <= 7'd120;
            r_gm2_mel <= 7'd121;
            r_def_part <= 4'd9;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mprmt_pkg::REG_MODE:     r_mode <= i_cfg_wdata[1:0];
                mprmt_pkg::REG_XG_RHY:   r_xg_rhy <= i_cfg_wdata;
                mprmt_pkg::REG_GM2_RHY:  r_gm2_rhy <= i_cfg_wdata;
                mprmt_pkg::REG_GM2_MEL:  r_gm2_mel <= i_cfg_wdata;
                mprmt_pkg::REG_DEF_PART: r_def_part <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    mprmt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[1:0]), .i_data_byte(s_axis_tdata[9:2]),
        .i_last_byte(s_axis_tlast), .i_part(s_axis_tdata[13:10]),
        .i_other_part(s_axis_tdata[17:14]), .i_bank_msb(s_axis_tdata[24:18]),
        .i_bank_lsb(s_axis_tdata[31:25]),
        .o_valid(f_valid), .i_ready(f_ready), .o_item(f_item)
    );

    mprmt_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_item(f_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    mprmt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .i_mode(r_mode), .i_xg_rhy(r_xg_rhy), .i_gm2_rhy(r_gm2_rhy),
        .i_gm2_mel(r_gm2_mel), .i_def_part(r_def_part),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {2'b00, res.shares_map, res.effective_lsb, res.effective_msb,
        res.is_rhythm, res.change_rhythm, res.change_part, res.change_valid};

    a_change_no_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.change_valid |-> !res.is_rhythm && !res.shares_map)
        else $error("change result carries query fields");

    a_share_needs_rhythm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.shares_map |-> res.is_rhythm)
        else $error("shared map without rhythm");

    a_queue_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_valid |=> !(m_axis_tvalid && !$past(m_axis_tvalid) ))
        else $error("result without queued command");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the MIDI part rhythm-mode tracker: a local model
// predicts map changes and query answers; the monitor compares each result.
// ============================================================================
module tb;

    typedef struct packed {
        logic       last;
        logic [6:0] lsb;
        logic [6:0] msb;
        logic [3:0] oth;
        logic [3:0] part;
        logic [7:0] dbyte;
        logic [1:0] op;
    } t_in;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 0;
    wire  [23:0] m_axis_tdata;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_addr = '0;
    logic [6:0]  i_cfg_wdata = '0;

    midi_part_rhythm_mode_tracker_top dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [1:0] mode;
    logic [6:0] xg_rhy, gm2_rhy, gm2_mel;
    logic [3:0] def_part;
    logic [1:0] map_tbl [16];
    logic       expl [16];
    logic [3:0] byte_cnt;
    logic [7:0] hdr [10];
    logic       pend_hit, pend_drum;

    t_in         pending_items[$];
    logic [23:0] expected_results[$];
    int  errors = 0;
    int  send_idle = 26, recv_idle = 54;
    bit  hold_recv = 0;
    bit  in_taken = 0;
    longint cycles = 0;

    function automatic void restore_maps();
        for (int i = 0; i < 16; i++) begin
            map_tbl[i] = 0;
            expl[i] = 0;
        end
        map_tbl[def_part] = 1;
    endfunction

    function automatic bit rhythm_of(logic [3:0] p);
        return map_tbl[p] != 0;
    endfunction

    // map > 2: odd -> rhythm, even -> melodic
    function automatic void write_map(logic [3:0] p, int m, bit mark);
        bit was, chg;
        logic [1:0] nv;
        was = map_tbl[p] != 0;
        if (mark) expl[p] = 1;
        if (m > 2) begin
            nv = (m & 1) ? 2'd1 : 2'd0;
            chg = was != (m & 1);
        end else begin
            nv = m[1:0];
            chg = map_tbl[p] != nv;
        end
        if (chg) begin
            map_tbl[p] = nv;
            expected_results.push_back({2'b0, 16'b0, (nv != 0), p, 1'b1});
        end
    endfunction

    function automatic int gs_block_part(logic [7:0] b);
        if (b == 8'h10) return 9;
        if (b >= 8'h11 && b <= 8'h19) return b - 8'h11;
        if (b >= 8'h1a && b <= 8'h1f) return b - 8'h10;
        return -1;
    endfunction

    function automatic void judge_sysex(int size, logic [7:0] lb);
        logic [6:0] sum, ck;
        int p;
        if (size == 11 && hdr[0] == 8'hf0 && hdr[1] == 8'h41 && hdr[2] <= 8'h1f
            && hdr[3] == 8'h42 && hdr[4] == 8'h12 && hdr[5] == 8'h40
            && hdr[7] == 8'h15 && hdr[8] <= 8'h02 && lb == 8'hf7) begin
            sum = 7'(hdr[5] + hdr[6] + hdr[7] + hdr[8]);
            ck = 7'(8'h80 - sum);
            p = gs_block_part(hdr[6]);
            if (p >= 0 && hdr[9] == {1'b0, ck}) begin
                write_map(p[3:0], hdr[8], 1);
                return;
            end
        end
        if (size < 9 || hdr[0] != 8'hf0 || lb != 8'hf7 || hdr[1] != 8'h43
            || hdr[2][7:4] != 4'h1 || hdr[3] != 8'h4c || hdr[4] != 8'h08
            || hdr[5] >= 16) return;
        if (!pend_hit) return;
        write_map(hdr[5][3:0], pend_drum ? 3 : 4, 1);
    endfunction

    function automatic void predict_item(t_in it);
        int idx;
        bit r, rq, want;
        case (it.op)
            mprmt_pkg::OP_SYSEX: begin
                idx = byte_cnt;
                if (idx < 10) hdr[idx] = it.dbyte;
                if (it.last) begin
                    judge_sysex(idx + 1, it.dbyte);
                    byte_cnt = 0;
                    pend_hit = 0;
                    pend_drum = 0;
                end else begin
                    if (idx >= 7 && int'(hdr[6]) + idx - 7 == 7) begin
                        pend_hit = 1;
                        pend_drum = it.dbyte != 0;
                    end
                    if (byte_cnt < 15) byte_cnt++;
                end
            end
            mprmt_pkg::OP_BANK: begin
                if (expl[it.part]) return;
                if (mode == mprmt_pkg::MODE_XG) want = it.msb == xg_rhy;
                else if (mode == mprmt_pkg::MODE_GM2) begin
                    if (it.msb == gm2_rhy) want = 1;
                    else if (it.msb == gm2_mel) want = 0;
                    else return;
                end else return;
                if (rhythm_of(it.part) == want) return;
                write_map(it.part, want ? 3 : 4, 0);
            end
            mprmt_pkg::OP_QUERY: begin
                r = rhythm_of(it.part);
                rq = mode == mprmt_pkg::MODE_GS && r && rhythm_of(it.oth)
                     && map_tbl[it.part] == map_tbl[it.oth];
                expected_results.push_back({2'b0, rq,
                    r ? 7'd0 : it.lsb,
                    r ? (mode == mprmt_pkg::MODE_XG ? xg_rhy : gm2_rhy) : it.msb,
                    r, 5'b0, 1'b0});
            end
            default: restore_maps();
        endcase
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_taken) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                    t_in it;
                    it = pending_items.pop_front();
                    s_axis_tvalid <= 1;
                    s_axis_tdata <= {it.lsb, it.msb, it.oth, it.part, it.dbyte, it.op};
                    s_axis_tlast <= it.last;
                end else
                    s_axis_tvalid <= 0;
            end
            m_axis_tready <= !hold_recv && $urandom_range(99) >= recv_idle;
        end
    end

    // accept side: predict at the handshake edge
    always @(posedge i_clk) begin
        t_in it;
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            it.op = s_axis_tdata[1:0];
            it.dbyte = s_axis_tdata[9:2];
            it.part = s_axis_tdata[13:10];
            it.oth = s_axis_tdata[17:14];
            it.msb = s_axis_tdata[24:18];
            it.lsb = s_axis_tdata[31:25];
            it.last = s_axis_tlast;
            predict_item(it);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [23:0] exp_r;
        cycles++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_axis_tdata[21:0] != exp_r[21:0]) begin
                    $display("%0t mismatch: expected %h actual %h",
                             $time, exp_r[21:0], m_axis_tdata[21:0]);
                    errors++;
                end
            end
        end
        if (cycles > 400000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] a, logic [6:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_addr <= a;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (a)
            mprmt_pkg::REG_MODE:     mode = v[1:0];
            mprmt_pkg::REG_XG_RHY:   xg_rhy = v;
            mprmt_pkg::REG_GM2_RHY:  gm2_rhy = v;
            mprmt_pkg::REG_GM2_MEL:  gm2_mel = v;
            mprmt_pkg::REG_DEF_PART: def_part = v[3:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    function automatic t_in rnd_item();
        t_in it;
        it = t_in'({$urandom, $urandom});
        return it;
    endfunction

    task automatic push_sysex(logic [7:0] b[], bit closed);
        t_in it;
        foreach (b[i]) begin
            it = rnd_item();
            it.op = mprmt_pkg::OP_SYSEX;
            it.dbyte = b[i];
            it.last = closed && i == b.size() - 1;
            pending_items.push_back(it);
        end
    endtask

    task automatic push_gs(logic [7:0] blk, logic [7:0] m, bit good);
        logic [7:0] b[];
        logic [6:0] s;
        s = 7'(8'h40 + blk + 8'h15 + m);
        b = '{8'hf0, 8'h41, 8'h10, 8'h42, 8'h12, 8'h40, blk, 8'h15, m,
              {1'b0, 7'(8'h80 - s)}, 8'hf7};
        if (!good) b[$urandom_range(10)] = $urandom;
        push_sysex(b, 1);
    endtask

    task automatic push_xg(logic [7:0] p, logic [7:0] addr, int n, bit good);
        logic [7:0] b[];
        b = new[7 + n + 1];
        b[0] = 8'hf0; b[1] = 8'h43; b[2] = 8'h10 | 8'($urandom_range(15));
        b[3] = 8'h4c; b[4] = 8'h08; b[5] = p; b[6] = addr;
        for (int i = 0; i < n; i++) b[7 + i] = $urandom_range(3) == 0 ? 8'd0 : $urandom;
        b[7 + n] = 8'hf7;
        if (!good) b[$urandom_range(7 + n)] = $urandom;
        push_sysex(b, 1);
    endtask

    task automatic push_simple(logic [1:0] op, logic [3:0] p, logic [6:0] msb);
        t_in it;
        it = rnd_item();
        it.op = op;
        it.part = p;
        it.msb = msb;
        pending_items.push_back(it);
    endtask

    task automatic random_batch(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 12) push_gs(8'h10 + $urandom_range(15), $urandom_range(3),
                                $urandom_range(3) != 0);
            else if (k < 24) push_xg($urandom_range(17), $urandom_range(9),
                                     $urandom_range(1, 6), $urandom_range(3) != 0);
            else if (k < 50) push_simple(mprmt_pkg::OP_BANK, $urandom,
                $urandom_range(1) ? 7'($urandom) :
                ($urandom_range(1) ? (mode == mprmt_pkg::MODE_XG ? xg_rhy : gm2_rhy)
                                   : gm2_mel));
            else if (k < 85) push_simple(mprmt_pkg::OP_QUERY, $urandom, $urandom);
            else if (k < 88) push_simple(mprmt_pkg::OP_CLEAR, $urandom, $urandom);
            else begin
                t_in it;
                it = rnd_item();
                it.op = mprmt_pkg::OP_SYSEX;
                pending_items.push_back(it);
            end
        end
    endtask

    initial begin
        mode = mprmt_pkg::MODE_XG; xg_rhy = 127; gm2_rhy = 120; gm2_mel = 121;
        def_part = 9;
        byte_cnt = 0; pend_hit = 0; pend_drum = 0;
        for (int i = 0; i < 10; i++) hdr[i] = 0;
        restore_maps();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;

        // directed
        push_simple(mprmt_pkg::OP_QUERY, 4'd9, 7'h7f);
        push_simple(mprmt_pkg::OP_BANK, 4'd0, 7'd127);
        push_simple(mprmt_pkg::OP_QUERY, 4'd0, 7'd0);
        push_gs(8'h10, 8'd2, 1);
        push_gs(8'h1f, 8'd1, 1);
        push_gs(8'h11, 8'd0, 0);
        push_xg(8'd3, 8'd7, 1, 1);
        push_xg(8'd4, 8'd5, 4, 1);
        push_xg(8'd15, 8'd0, 9, 1);
        push_simple(mprmt_pkg::OP_BANK, 4'd3, 7'd0);
        push_simple(mprmt_pkg::OP_QUERY, 4'd15, 7'd0);
        push_simple(mprmt_pkg::OP_CLEAR, 4'd0, 7'd0);
        push_simple(mprmt_pkg::OP_QUERY, 4'd3, 7'd5);
        drain();

        // long hold on the receiver while the sender keeps offering
        hold_recv = 1;
        for (int i = 0; i < 12; i++) push_simple(mprmt_pkg::OP_QUERY, $urandom, $urandom);
        repeat (60) @(negedge i_clk);
        hold_recv = 0;
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            cfg_write(mprmt_pkg::REG_MODE, 7'(ph % 4));
            cfg_write(mprmt_pkg::REG_XG_RHY, ph == 0 ? 7'd0 : 7'($urandom));
            cfg_write(mprmt_pkg::REG_GM2_RHY,
                      ph == 1 ? 7'd127 : 7'($urandom_range(0, 3)));
            cfg_write(mprmt_pkg::REG_GM2_MEL,
                      ph == 1 ? 7'd0 : 7'($urandom_range(4, 7)));
            cfg_write(mprmt_pkg::REG_DEF_PART, ph == 2 ? 7'd15 : 7'($urandom));
            push_simple(mprmt_pkg::OP_CLEAR, 0, 0);
            if (ph == 2) begin send_idle = 54; recv_idle = 26; end
            if (ph == 4) begin send_idle = 0; recv_idle = 0; end
            random_batch(24);
            drain();
        end
        repeat (10) @(negedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
